// ===== rtl/grdf_pkg.sv =====
// Shared types and constants for the gamepad report to DBUS frame unit.
package grdf_pkg;

  localparam int unsigned CapDepth = 11;
  localparam int unsigned CntW     = 5;
  localparam logic [CntW-1:0] CntMax = 5'd31;

  localparam logic [15:0] HeaderRst = 16'd50593;
  localparam logic [10:0] LowRst    = 11'd364;
  localparam logic [10:0] HighRst   = 11'd1684;
  localparam logic [4:0]  MinLenRst = 5'd19;

  localparam logic [10:0] DivK  = 11'd1023;
  localparam logic [10:0] DivK2 = 11'd2046;
  localparam logic [11:0] DivK3 = 12'd3069;

  // key word bit positions
  localparam int unsigned KeyL1 = 6;
  localparam int unsigned KeyR1 = 7;
  localparam int unsigned KeyL2 = 8;
  localparam int unsigned KeyR2 = 9;
  localparam int unsigned KeyC1 = 10;
  localparam int unsigned KeyC2 = 11;

  // DBUS switch codes
  localparam logic [1:0] SwUp   = 2'd1;
  localparam logic [1:0] SwDown = 2'd2;
  localparam logic [1:0] SwMid  = 2'd3;

  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_HIGH   = 2'd2,
    CFG_MINLEN = 2'd3
  } cfg_idx_e;

  // decoded report, handed from the front end to the mapping lanes
  typedef struct packed {
    logic [10:0] ld;
    logic [9:0]  lp;
    logic [9:0]  rd;
    logic [9:0]  rp;
    logic [1:0]  sw1;
    logic [1:0]  sw2;
    logic [15:0] keys;
    logic        mode;
  } report_t;

endpackage

// ===== rtl/grdf_front.sv =====
// Byte capture, report check, stick decode and board mode register.
module grdf_front import grdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  logic        next_ready_i,
  input  logic [15:0] header_code_i,
  input  logic [4:0]  min_len_i,
  output logic        rep_valid_o,
  output report_t     rep_o
);

  logic [CntW-1:0] count_q, count_d, len;
  logic [7:0]      cap_q [CapDepth];
  logic [7:0]      b     [CapDepth];
  logic            mode_q, mode_d, new_mode;
  logic            rep_valid_q, accept, ok;
  report_t         rep_q, rep_d;
  logic [10:0]     rd_sum, rp_sum;

  assign in_ready_o = !rep_valid_q || next_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // current byte overrides the stored one at its own position
  always_comb begin
    for (int i = 0; i < CapDepth; i++) begin
      b[i] = (count_q == CntW'(i)) ? in_byte_i : cap_q[i];
    end
  end

  assign len = (count_q == CntMax) ? CntMax : count_q + 1'b1;
  assign ok  = (len >= min_len_i) && ({b[1], b[0]} == header_code_i);

  always_comb begin
    rep_d.keys = {b[10], b[9]};
    rep_d.ld   = (11'd1024 - {1'b0, b[2], 2'b00}) | {9'd0, b[3][7:6]};
    rep_d.lp   = {b[3][5:0], b[4][7:4]};
    rd_sum     = 11'd512 + {1'b0, b[4][3:0], b[5][7:2]};
    rp_sum     = 11'd512 + {1'b0, b[5][1:0], b[6]};
    if (mode_q) begin
      rep_d.rd = {b[4][3:0], b[5][7:2]};
      rep_d.rp = {b[5][1:0], b[6]};
    end else begin
      rep_d.rd = rd_sum[10:1];
      rep_d.rp = rp_sum[10:1];
    end
    if (rep_d.keys[KeyL1])      rep_d.sw1 = SwDown;
    else if (rep_d.keys[KeyL2]) rep_d.sw1 = SwUp;
    else                        rep_d.sw1 = SwMid;
    if (rep_d.keys[KeyR1])      rep_d.sw2 = SwMid;
    else if (rep_d.keys[KeyR2]) rep_d.sw2 = SwUp;
    else                        rep_d.sw2 = SwDown;
    if (rep_d.keys[KeyC2])      new_mode = 1'b0;
    else if (rep_d.keys[KeyC1]) new_mode = 1'b1;
    else                        new_mode = mode_q;
    rep_d.mode = new_mode;
  end

  always_comb begin
    count_d = count_q;
    mode_d  = mode_q;
    if (accept) begin
      count_d = in_last_i ? '0 : len;
      if (in_last_i && ok) mode_d = new_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b1;
      rep_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      mode_q  <= mode_d;
      if (in_ready_o) rep_valid_q <= accept && in_last_i && ok;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CapDepth; i++) begin
      if (accept && count_q == CntW'(i)) cap_q[i] <= in_byte_i;
    end
    if (in_ready_o) rep_q <= rep_d;
  end

  assign rep_valid_o = rep_valid_q;
  assign rep_o       = rep_q;

endmodule

// ===== rtl/grdf_lane.sv =====
// One stick channel: registered product, then divide by 1023 and offset.
module grdf_lane import grdf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [10:0] value_i,
  input  logic [10:0] dbus_low_i,
  input  logic [10:0] dbus_high_i,
  output logic [15:0] mapped_o
);

  logic signed [11:0] diff;
  logic signed [23:0] prod_d, prod_q;
  logic [23:0]        mag;
  logic [11:0]        hi_part;
  logic [12:0]        rem;
  logic [1:0]         corr;
  logic [11:0]        quo;

  assign diff   = $signed({1'b0, dbus_high_i}) - $signed({1'b0, dbus_low_i});
  assign prod_d = $signed({1'b0, value_i}) * diff;

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  // x / 1023 with x = 1024a + b: quotient a plus floor((a + b) / 1023)
  always_comb begin
    mag     = prod_q[23] ? 24'(-prod_q) : prod_q;
    hi_part = mag[21:10];
    rem     = {1'b0, hi_part} + {3'b000, mag[9:0]};
    if (rem >= {1'b0, DivK3})          corr = 2'd3;
    else if (rem >= {2'b00, DivK2})    corr = 2'd2;
    else if (rem >= {2'b00, DivK})     corr = 2'd1;
    else                               corr = 2'd0;
    quo = hi_part + {10'd0, corr};
    if (prod_q[23]) mapped_o = {5'd0, dbus_high_i} + {4'd0, quo};
    else            mapped_o = {5'd0, dbus_high_i} - {4'd0, quo};
  end

endmodule

// ===== rtl/gamepad_report_to_dbus_frame_unit.sv =====
// Top level of the gamepad report to DBUS frame unit.
//
// Input stream: one report byte per item on s_axis_tdata, tlast on the
// final byte. The final byte closes the report; a report that is too short
// or has the wrong header word is dropped and gives no output item.
// Output stream: one item per good report, tdata holding the six DBUS bytes
// and the key word, tuser the target (1 chassis, 0 arm).
// Config: cfg_we_i writes register cfg_idx_i with cfg_data_i at the edge.
// The user must write only while the unit is idle; nothing enforces it.
// Throughput: one byte per cycle, back to back, reports of any length,
// while no stall holds the input (see below). Path: the decode register
// loads on the edge that takes an item's last byte, then the product
// register, then the output register, which drives the output item.
// Stall: each stage holds while the one after it is full and stalled; an
// empty stage still takes data, so input keeps flowing until every stage
// holds a report. Once the decode stage holds a stalled report, every byte
// waits, closing or not.
// Reset: byte count cleared, board mode set to chassis, config registers
// back to their defaults, no item pending. Capture bytes are not cleared.
module gamepad_report_to_dbus_frame_unit import grdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // report byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_of_report
  // DBUS frame stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // frame_byte0..frame_byte5, key_word
  output logic        m_axis_tuser    // to_chassis
);

  logic [15:0] header_q;
  logic [10:0] low_q, high_q;
  logic [4:0]  minlen_q;

  logic        rep_valid;
  report_t     rep;
  logic        prod_valid_q, out_valid_q;
  logic        prod_ready, out_ready;
  logic [1:0]  sw1_q, sw2_q;
  logic [15:0] keys_q;
  logic        mode_q;
  logic [15:0] mld, mlp, mrd, mrp;
  logic [63:0] tdata_q, tdata_d;
  logic        tuser_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderRst;
      low_q    <= LowRst;
      high_q   <= HighRst;
      minlen_q <= MinLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER: header_q <= cfg_data_i;
        CFG_LOW:    low_q    <= cfg_data_i[10:0];
        CFG_HIGH:   high_q   <= cfg_data_i[10:0];
        CFG_MINLEN: minlen_q <= cfg_data_i[4:0];
      endcase
    end
  end

  // per-stage handshake: a stage loads when it is empty or drains
  assign out_ready  = !out_valid_q || m_axis_tready;
  assign prod_ready = !prod_valid_q || out_ready;

  grdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .next_ready_i (prod_ready),
    .header_code_i(header_q),
    .min_len_i    (minlen_q),
    .rep_valid_o  (rep_valid),
    .rep_o        (rep)
  );

  grdf_lane u_lane_ld (
    .clk_i(clk_i), .en_i(prod_ready), .value_i(rep.ld),
    .dbus_low_i(low_q), .dbus_high_i(high_q), .mapped_o(mld)
  );
  grdf_lane u_lane_lp (
    .clk_i(clk_i), .en_i(prod_ready), .value_i({1'b0, rep.lp}),
    .dbus_low_i(low_q), .dbus_high_i(high_q), .mapped_o(mlp)
  );
  grdf_lane u_lane_rd (
    .clk_i(clk_i), .en_i(prod_ready), .value_i({1'b0, rep.rd}),
    .dbus_low_i(low_q), .dbus_high_i(high_q), .mapped_o(mrd)
  );
  grdf_lane u_lane_rp (
    .clk_i(clk_i), .en_i(prod_ready), .value_i({1'b0, rep.rp}),
    .dbus_low_i(low_q), .dbus_high_i(high_q), .mapped_o(mrp)
  );

  // side fields travel alongside the product stage
  always_ff @(posedge clk_i) begin
    if (prod_ready) begin
      sw1_q  <= rep.sw1;
      sw2_q  <= rep.sw2;
      keys_q <= rep.keys;
      mode_q <= rep.mode;
    end
  end

  // DBUS packing, 11 bits per channel in the order rd, rp, ld, lp
  always_comb begin
    tdata_d[7:0]   = mrd[7:0];
    tdata_d[15:8]  = mrd[15:8] | {mrp[4:0], 3'b000};
    tdata_d[23:16] = mrp[12:5] | {mld[1:0], 6'd0};
    tdata_d[31:24] = mld[9:2];
    tdata_d[39:32] = {2'b00, mld[15:10]} | {mlp[6:0], 1'b0};
    tdata_d[47:40] = {sw2_q, sw1_q, 4'd0} | mlp[14:7];
    tdata_d[63:48] = keys_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) prod_valid_q <= rep_valid;
      if (out_ready)  out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      tdata_q <= tdata_d;
      tuser_q <= mode_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

// ===== rtl/grdf_checker.sv =====
// Port-level checks for the gamepad report to DBUS frame unit, with bind.
module grdf_checker import grdf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // switch codes are never zero
  a_sw_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:46] != 2'b00 && m_axis_tdata[45:44] != 2'b00)
    else $error("zero switch code in frame");

  // c2 forces arm, c1 alone forces chassis
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[48 + KeyC2] || m_axis_tdata[48 + KeyC1]) |->
      m_axis_tuser == !m_axis_tdata[48 + KeyC2])
    else $error("target does not follow mode keys");

  // L1 gives the down code on switch 1
  a_l1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[48 + KeyL1] |-> m_axis_tdata[45:44] == SwDown)
    else $error("switch 1 does not follow L1");

endmodule

bind gamepad_report_to_dbus_frame_unit grdf_checker u_grdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the gamepad report to DBUS frame unit.
`timescale 1ns / 100ps

module testbench;
  import grdf_pkg::*;

  // Full-scale stick value used by the DBUS mapping.
  localparam longint StickFull = 1023;

  // One expected DBUS frame: target flag, six packed bytes, key word.
  typedef struct packed {
    logic [15:0]     key_word;
    logic [5:0][7:0] fb;         // fb[0] is DBUS byte 0
    logic            to_chassis;
  } dbus_frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tlast;   // last_of_report
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // frame_byte0..frame_byte5, key_word
  logic        m_axis_tuser;   // to_chassis

  gamepad_report_to_dbus_frame_unit u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the byte capture and the
  // board mode. Updated only when an item is actually taken by the unit.
  // ---------------------------------------------------------------------------
  logic [15:0] hdr_cfg;
  logic [10:0] low_cfg;
  logic [10:0] high_cfg;
  logic [4:0]  minlen_cfg;

  int unsigned rpt_count;          // bytes seen so far in the open report
  logic [7:0]  rpt_bytes [11];     // report bytes 0..10
  bit   [10:0] rpt_written;        // capture entries written since reset
  bit          mode_chassis;

  dbus_frame_t pending_frames[$];  // frames owed by the unit, oldest first

  // Handshake pacing, in percent of cycles.
  int unsigned gap_pct;
  int unsigned stall_pct;

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned reports_sent;
  int unsigned frames_checked;

  // Stick value to DBUS channel: high - trunc(v * (high - low) / 1023).
  // Signed math so an inverted range truncates toward zero, then wraps.
  function automatic logic [15:0] map_to_dbus(input int unsigned v);
    longint span;
    longint quo;
    span = longint'(high_cfg) - longint'(low_cfg);
    quo  = (longint'(v) * span) / StickFull;
    return 16'(longint'(high_cfg) - quo);
  endfunction

  // Feed one accepted byte to the predictor; a closing byte may owe a frame.
  function automatic void absorb_report_byte(input logic [7:0] d, input bit last);
    int unsigned len;
    int unsigned ld, lp, rd, rp;
    int unsigned mld, mlp, mrd, mrp;
    logic [1:0]  s1, s2;
    logic [15:0] keys;
    dbus_frame_t f;
    if (rpt_count < CapDepth) begin
      rpt_bytes[rpt_count]   = d;
      rpt_written[rpt_count] = 1'b1;
    end
    len = rpt_count + 1;
    if (len > CntMax) len = CntMax;
    if (!last) begin
      rpt_count = len;
      return;
    end
    rpt_count = 0;

    // Too short or wrong header word: dropped, mode untouched.
    if (len < minlen_cfg) return;
    if ({rpt_bytes[1], rpt_bytes[0]} != hdr_cfg) return;

    keys = {rpt_bytes[10], rpt_bytes[9]};
    ld = ((1024 - (int'(rpt_bytes[2]) << 2)) | (int'(rpt_bytes[3]) >> 6)) & 'hFFFF;
    lp = ((int'(rpt_bytes[3]) & 'h3F) << 4) | (int'(rpt_bytes[4]) >> 4);
    rd = ((int'(rpt_bytes[4]) & 'h0F) << 6) | (int'(rpt_bytes[5]) >> 2);
    rp = ((int'(rpt_bytes[5]) & 'h03) << 8) | int'(rpt_bytes[6]);

    // Arm mode (mode before this report) pulls the right stick toward center.
    if (!mode_chassis) begin
      rd = (512 + rd) >> 1;
      rp = (512 + rp) >> 1;
    end
    mld = map_to_dbus(ld);
    mlp = map_to_dbus(lp);
    mrd = map_to_dbus(rd);
    mrp = map_to_dbus(rp);

    if (keys[KeyL1])      s1 = SwDown;
    else if (keys[KeyL2]) s1 = SwUp;
    else                  s1 = SwMid;
    if (keys[KeyR1])      s2 = SwMid;
    else if (keys[KeyR2]) s2 = SwUp;
    else                  s2 = SwDown;

    // c2 clears after c1 sets, so c2 wins when both are held.
    if (keys[KeyC1]) mode_chassis = 1'b1;
    if (keys[KeyC2]) mode_chassis = 1'b0;

    f.to_chassis = mode_chassis;
    f.key_word   = keys;
    f.fb[0] = 8'(mrd);
    f.fb[1] = 8'((mrd >> 8) | ((mrp << 3) & 'hF8));
    f.fb[2] = 8'((mrp >> 5) | ((mld << 6) & 'hC0));
    f.fb[3] = 8'(mld >> 2);
    f.fb[4] = 8'((mld >> 10) | ((mlp << 1) & 'hFE));
    f.fb[5] = 8'((int'(s2) << 6) | (int'(s1) << 4) | (mlp >> 7));
    pending_frames.push_back(f);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, and a field-by-field check of every
  // frame taken against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : frame_check
    dbus_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t ns: frame with none expected, actual tdata 0x%h tuser %0b",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        check_field("to_chassis", want.to_chassis, m_axis_tuser);
        for (int i = 0; i < 6; i++) begin
          check_field($sformatf("frame_byte%0d", i), want.fb[i], m_axis_tdata[8*i +: 8]);
        end
        check_field("key_word", want.key_word, m_axis_tdata[63:48]);
        frames_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offer one byte, with random gaps before it; returns at the edge that takes
  // it. tvalid stays high into the next call so back-to-back bytes never drop.
  task automatic push_byte(input logic [7:0] d, input bit last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_report_byte(d, last);
    bytes_sent++;
  endtask

  // Build and send one report. stick_fill < 0 gives random stick bytes,
  // otherwise bytes 2..6 all take that value.
  task automatic send_report(input logic [15:0] hdr, input int unsigned len,
                             input logic [15:0] keys, input int stick_fill);
    logic [7:0] rpt [$];
    // a short report reuses old capture bytes; make sure all of them exist
    if (rpt_written != '1 && len < CapDepth) len = CapDepth;
    if (len == 0) len = 1;
    for (int i = 0; i < len; i++) begin
      if (i == 0)                       rpt.push_back(hdr[7:0]);
      else if (i == 1)                  rpt.push_back(hdr[15:8]);
      else if (i <= 6 && stick_fill >= 0) rpt.push_back(8'(stick_fill));
      else if (i == 9)                  rpt.push_back(keys[7:0]);
      else if (i == 10)                 rpt.push_back(keys[15:8]);
      else                              rpt.push_back(8'($urandom));
    end
    for (int i = 0; i < len; i++) push_byte(rpt[i], i == len - 1);
    reports_sent++;
  endtask

  // Stop sending, let every owed frame arrive, then give the pipeline time to
  // flush dropped reports before anything else happens.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_HEADER: hdr_cfg    = val;
      CFG_LOW:    low_cfg    = val[10:0];
      CFG_HIGH:   high_cfg   = val[10:0];
      CFG_MINLEN: minlen_cfg = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] hdr, input logic [10:0] lo,
                                input logic [10:0] hi, input logic [4:0] minl);
    wait_results_drained();
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_LOW, 16'(lo));
    write_reg(CFG_HIGH, 16'(hi));
    write_reg(CFG_MINLEN, 16'(minl));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Stick bytes at both ends with reset registers; the first report is long
  // enough to fill the whole capture.
  task automatic test_stick_extremes();
    send_report(HeaderRst, MinLenRst, 16'h0000, 8'h00);
    send_report(HeaderRst, MinLenRst, 16'h0000, 8'hFF);
  endtask

  // Switch code priorities: L1 and R1 alone, L2 and R2 alone, then all four held.
  task automatic test_switch_keys();
    send_report(HeaderRst, MinLenRst, (16'd1 << KeyL1) | (16'd1 << KeyR1), -1);
    send_report(HeaderRst, MinLenRst, (16'd1 << KeyL2) | (16'd1 << KeyR2), -1);
    send_report(HeaderRst, MinLenRst, (16'd1 << KeyL1) | (16'd1 << KeyL2) |
                                      (16'd1 << KeyR1) | (16'd1 << KeyR2), -1);
  endtask

  // Board mode: c2 to arm, halving in arm mode, c2 beating c1, back to chassis.
  task automatic test_board_mode();
    send_report(HeaderRst, MinLenRst, 16'd1 << KeyC2, 8'hFF);
    send_report(HeaderRst, MinLenRst, 16'h0000, 8'hFF);
    send_report(HeaderRst, MinLenRst, 16'h0000, 8'h00);
    send_report(HeaderRst, MinLenRst, (16'd1 << KeyC1) | (16'd1 << KeyC2), -1);
    send_report(HeaderRst, MinLenRst, 16'hFFFF, -1);
    send_report(HeaderRst, MinLenRst, 16'd1 << KeyC1, 8'h00);
  endtask

  // Report framing: one short, a bad header, exact minimum, and the count
  // saturating on long reports.
  task automatic test_report_framing();
    send_report(HeaderRst, MinLenRst - 1, 16'h0000, -1);
    send_report(HeaderRst ^ 16'h0100, MinLenRst, 16'h0000, -1);
    send_report(HeaderRst, MinLenRst, 16'h00F0, -1);
    send_report(HeaderRst, CntMax, 16'h0300, -1);
    send_report(HeaderRst, 40, 16'h0C00, -1);
  endtask

  // Register extremes: zero header, tiny and zero minimum lengths (short reports
  // reuse older capture bytes), full, inverted and empty DBUS ranges, and the
  // largest minimum length.
  task automatic test_register_extremes();
    write_all_regs(16'h0000, LowRst, HighRst, 5'd1);
    send_report(16'h0000, 2, 16'h0000, -1);
    send_report(16'h0000, 1, 16'h0000, -1);
    wait_results_drained();
    write_reg(CFG_MINLEN, 16'd0);
    send_report(16'h0000, 1, 16'h0000, -1);
    send_report(16'h0000, 5, 16'h0000, -1);
    write_all_regs(16'h0000, 11'd0, 11'd2047, 5'd11);
    send_report(16'h0000, 11, 16'h0000, 8'h00);
    send_report(16'h0000, 11, 16'h0000, 8'hFF);
    write_all_regs(16'h0000, 11'd2047, 11'd0, 5'd11);
    send_report(16'h0000, 11, 16'h0000, 8'h00);
    send_report(16'h0000, 11, 16'h0000, 8'hFF);
    send_report(16'h0000, 11, 16'd1 << KeyC2, -1);
    write_all_regs(16'h0000, 11'd1000, 11'd1000, 5'd11);
    send_report(16'h0000, 11, 16'd1 << KeyC1, -1);
    write_all_regs(16'hFFFF, LowRst, HighRst, CntMax);
    send_report(16'hFFFF, CntMax - 1, 16'h0000, -1);
    send_report(16'hFFFF, CntMax, 16'h0000, -1);
  endtask

  // Random traffic in four phases, each with its own register setting and
  // handshake idling mix. Most reports are well formed with random content;
  // the rest carry a flipped header bit or end early.
  task automatic test_random_traffic();
    logic [15:0] hdr;
    logic [15:0] keys;
    logic [10:0] lo, hi;
    logic [4:0]  minl;
    int unsigned start, len_floor, len, pick;
    int          fill;
    bit          mid_drained;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          hdr = HeaderRst; lo = LowRst; hi = HighRst; minl = MinLenRst;
        end
        1: begin
          hdr = 16'($urandom); lo = 11'd0; hi = 11'd2047; minl = 5'd1;
        end
        2: begin
          hdr = 16'hFFFF; lo = 11'd2047; hi = 11'd0; minl = CntMax;
        end
        default: begin
          hdr = 16'h0000; lo = 11'($urandom); hi = 11'($urandom);
          minl = 5'($urandom_range(0, 12));
        end
      endcase
      write_all_regs(hdr, lo, hi, minl);
      gap_pct   = (ph == 1) ? 55 : (ph == 3) ? 11 : 0;
      stall_pct = (ph == 2) ? 55 : (ph == 3) ? 11 : 0;
      len_floor = (minl == 0) ? 1 : minl;
      start = bytes_sent;
      mid_drained = 1'b0;
      while (bytes_sent - start < 350) begin
        // halfway through, the sender holds off until the unit is empty
        if (!mid_drained && bytes_sent - start >= 175) begin
          wait_results_drained();
          mid_drained = 1'b1;
        end
        pick = $urandom_range(0, 99);
        keys = 16'($urandom);
        fill = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 255 : 0) : -1;
        if ($urandom_range(0, 11) == 0) len = $urandom_range(CntMax, 40);
        else                            len = $urandom_range(len_floor, len_floor + 12);
        if (pick < 75) begin
          send_report(hdr, len, keys, fill);
        end else if (pick < 88 || len_floor == 1) begin
          send_report(hdr ^ (16'd1 << $urandom_range(0, 15)), len, keys, fill);
        end else begin
          send_report(hdr, $urandom_range(1, len_floor - 1), keys, fill);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_HEADER;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    error_count   = 0;
    bytes_sent    = 0;
    reports_sent  = 0;
    frames_checked = 0;
    // predictor follows the unit's reset values
    hdr_cfg      = HeaderRst;
    low_cfg      = LowRst;
    high_cfg     = HighRst;
    minlen_cfg   = MinLenRst;
    rpt_count    = 0;
    rpt_written  = '0;
    mode_chassis = 1'b1;
    foreach (rpt_bytes[i]) rpt_bytes[i] = 8'h00;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_stick_extremes();
    test_switch_keys();
    test_board_mode();
    test_report_framing();
    test_register_extremes();
    test_random_traffic();

    wait_results_drained();
    $display("Sent %0d report bytes in %0d reports; %0d DBUS frames compared.",
             bytes_sent, reports_sent, frames_checked);
    $display("Covered stick and key extremes, board mode changes, dropped reports, and"
             , " four register settings under mixed backpressure.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/grdf_pkg.sv
rtl/grdf_front.sv
rtl/grdf_lane.sv
rtl/gamepad_report_to_dbus_frame_unit.sv
rtl/grdf_checker.sv
sim/testbench.sv
